@@ rtl/lbcd_pkg.sv @@
// Shared widths and controller/datapath interface types for the LRU block cache directory.
package lbcd_pkg;

    localparam int BLOCK_W  = 52;
    localparam int SECTOR_W = 55;
    localparam int SLOT_W   = 4;

    // controller -> datapath
    typedef struct packed {
        logic start;        // latch request, restart the tag scan
        logic scan;         // advance the tag scan by one slot
        logic victim_rd;    // read the tag of the least recent slot
        logic hit_commit;   // move hit slot to front, emit hit result
        logic miss_commit;  // tag new block, move to front, emit miss result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;        // compared tag equals the request
        logic done;         // every slot in use has been compared
        logic full;         // all slots in use, a miss must evict
        logic out_free;     // result register can take a transaction
    } t_sts;

endpackage

@@ rtl/lbcd_ctrl.sv @@
// Sequencing state machine of the LRU block cache directory.
module lbcd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lbcd_pkg::t_sts i_sts,
    output lbcd_pkg::t_cmd o_cmd
);
    import lbcd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_HIT    = 5'b00100,
        ST_VICTIM = 5'b01000,
        ST_MISS   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.match) begin
                    n_state = ST_HIT;
                end else if (i_sts.done) begin
                    n_state = i_sts.full ? ST_VICTIM : ST_MISS;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_HIT: begin
                if (i_sts.out_free) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_VICTIM: begin
                o_cmd.victim_rd = 1'b1;
                n_state         = ST_MISS;
            end
            ST_MISS: begin
                if (i_sts.out_free) begin
                    o_cmd.miss_commit = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SCAN))
        else $error("accepted transaction did not start a scan");

    a_miss_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.done && !i_sts.match && !i_sts.full)
        |=> (r_state == ST_MISS))
        else $error("scan without match did not lead to a fill");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");

endmodule

@@ rtl/lbcd_datapath.sv @@
// Tag store, recency order, scan counters and result register of the LRU block cache directory.
module lbcd_datapath #(
    parameter int ENTRIES      = 16,
    parameter int BLOCK_SHIFT  = 12,
    parameter int SECTOR_SHIFT = 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [lbcd_pkg::BLOCK_W-1:0]       i_block_number,
    input  lbcd_pkg::t_cmd                     i_cmd,
    output lbcd_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hit,
    output logic [lbcd_pkg::SLOT_W-1:0]        o_slot,
    output logic [lbcd_pkg::SECTOR_W-1:0]      o_fill_sector,
    output logic                               o_evict_valid,
    output logic [lbcd_pkg::BLOCK_W-1:0]       o_evicted_block
);
    import lbcd_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SHIFT_D = BLOCK_SHIFT - SECTOR_SHIFT;
    localparam int SHIFT_L = (SHIFT_D >= 0) ? SHIFT_D : 0;
    localparam int SHIFT_R = (SHIFT_D < 0) ? -SHIFT_D : 0;

    logic [BLOCK_W-1:0] mem_tags [ENTRIES];

    logic [BLOCK_W-1:0] r_blk;
    logic [BLOCK_W-1:0] r_rd_data;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_scan_idx;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [IDX_W-1:0]   r_order [ENTRIES];

    logic               scan_more;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               full;
    logic [IDX_W-1:0]   victim_slot;
    logic [IDX_W-1:0]   miss_slot;
    logic [ENTRIES-1:0] pos_hit;
    logic [IDX_W-1:0]   hit_pos;
    logic [IDX_W-1:0]   mtf_pos;
    logic [IDX_W-1:0]   mtf_slot;
    logic               commit;
    logic [SECTOR_W-1:0] sector;

    assign full        = (r_used == CNT_W'(ENTRIES));
    assign victim_slot = r_order[ENTRIES-1];
    assign miss_slot   = full ? victim_slot : r_used[IDX_W-1:0];
    assign scan_more   = (r_scan_idx < r_used);
    assign rd_en       = (i_cmd.scan && scan_more) || i_cmd.victim_rd;
    assign rd_addr     = i_cmd.victim_rd ? victim_slot : r_scan_idx[IDX_W-1:0];
    assign commit      = i_cmd.hit_commit || i_cmd.miss_commit;

    // locate the hit slot among the live part of the recency order
    always_comb begin
        hit_pos = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            pos_hit[j] = (r_order[j] == r_cmp_idx) && (CNT_W'(j) < r_used);
            if (pos_hit[j]) begin
                hit_pos = hit_pos | IDX_W'(j);
            end
        end
    end

    assign mtf_pos  = i_cmd.hit_commit ? hit_pos
                    : (full ? IDX_W'(ENTRIES - 1) : r_used[IDX_W-1:0]);
    assign mtf_slot = i_cmd.hit_commit ? r_cmp_idx : miss_slot;
    assign sector   = (SECTOR_W'(r_blk) << SHIFT_L) >> SHIFT_R;

    assign o_sts.match    = r_cmp_vld && (r_rd_data == r_blk);
    assign o_sts.done     = !r_cmp_vld && !scan_more;
    assign o_sts.full     = full;
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // tag store: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem_tags[rd_addr];
        end
        if (i_cmd.miss_commit) begin
            mem_tags[miss_slot] <= r_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_blk <= i_block_number;
        end
        if (i_cmd.scan && scan_more) begin
            r_cmp_idx <= r_scan_idx[IDX_W-1:0];
        end
        // move to front: slide entries ahead of the position back by one
        if (commit) begin
            r_order[0] <= mtf_slot;
            for (int j = 1; j < ENTRIES; j++) begin
                if (IDX_W'(j) <= mtf_pos) begin
                    r_order[j] <= r_order[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= scan_more;
                if (scan_more) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
            end
            if (i_cmd.miss_commit && !full) begin
                r_used <= r_used + CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (commit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            o_hit           <= i_cmd.hit_commit;
            o_slot          <= SLOT_W'(mtf_slot);
            o_fill_sector   <= i_cmd.hit_commit ? '0 : sector;
            o_evict_valid   <= i_cmd.miss_commit && full;
            o_evicted_block <= (i_cmd.miss_commit && full) ? r_rd_data : '0;
        end
    end

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(ENTRIES))
        else $error("slot count beyond capacity");

    a_fill_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.miss_commit && !full) |=> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("fill into free slot did not advance slot count");

    a_commit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    a_hit_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_commit |-> $onehot(pos_hit))
        else $error("hit slot not found exactly once in recency order");

endmodule

@@ rtl/lru_block_cache_directory.sv @@
// Top level of the LRU block cache directory: controller plus datapath.
//
// Directory of a fully associative block cache with least-recently-used
// replacement. Each input transaction carries one block number; exactly one
// result transaction comes back with hit, slot, the first disk sector to fill
// from on a miss, and the block evicted to make room. Slots fill in order
// 0,1,2,... until all ENTRIES are in use; after that a miss reuses the least
// recent slot. The tag store is a single-port-read memory scanned one slot
// per cycle over the slots in use, with a registered read; a hit ends the
// scan at the matching slot and a miss is known once every slot in use has
// been compared. A hit or a fill into a free slot then commits; an eviction
// first reads the victim tag. The block takes one request at a time: the
// slowest case is a miss with the cache full. The result register decouples
// the output: a new request is accepted while the previous result still
// waits, and a commit stalls only while that result has not been taken. The
// slot count starts cleared after reset; tags and recency entries are only
// read for slots in use, so no clearing pass is needed.
module lru_block_cache_directory #(
    parameter int ENTRIES      = 16,
    parameter int BLOCK_SHIFT  = 12,
    parameter int SECTOR_SHIFT = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lbcd_pkg::BLOCK_W-1:0]  i_block_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [lbcd_pkg::SLOT_W-1:0]   o_slot,
    output logic [lbcd_pkg::SECTOR_W-1:0] o_fill_sector,
    output logic                          o_evict_valid,
    output logic [lbcd_pkg::BLOCK_W-1:0]  o_evicted_block
);
    import lbcd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing: accept, scan, optional victim read, commit
    lbcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // tag store, recency order and result register
    lbcd_datapath #(
        .ENTRIES      (ENTRIES),
        .BLOCK_SHIFT  (BLOCK_SHIFT),
        .SECTOR_SHIFT (SECTOR_SHIFT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_block_number  (i_block_number),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_fill_sector   (o_fill_sector),
        .o_evict_valid   (o_evict_valid),
        .o_evicted_block (o_evicted_block)
    );

endmodule

@@ tb/sv/tb_lru_block_cache_directory.sv @@
// Self-checking testbench for the LRU block cache directory, with a built-in LRU directory model.
module tb_lru_block_cache_directory;
    timeunit 1ns;
    timeprecision 1ps;

    import lbcd_pkg::*;

    // Geometry under test; the model below uses the same values.
    localparam int ENTRIES      = 16;
    localparam int BLOCK_SHIFT  = 12;
    localparam int SECTOR_SHIFT = 9;
    localparam int SHIFT_DIFF   = BLOCK_SHIFT - SECTOR_SHIFT;

    localparam logic [BLOCK_W-1:0]  BLK_MAX = '1;
    localparam int                  POOL_N  = 32;
    localparam int                  HOLD_CYCLES = 250;

    // One result transaction, field by field.
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] sector;
        logic                evict;
        logic [BLOCK_W-1:0]  evicted;
    } t_lookup_res;

    // One row of the directed table: the block, and a typed-in result if it is obvious.
    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        logic               typed;
        t_lookup_res        want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [BLOCK_W-1:0]    i_block_number = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_hit;
    logic [SLOT_W-1:0]     o_slot;
    logic [SECTOR_W-1:0]   o_fill_sector;
    logic                  o_evict_valid;
    logic [BLOCK_W-1:0]    o_evicted_block;

    // Directory model state: tag per slot, MRU-first slot order, count of slots filled.
    logic [BLOCK_W-1:0]    tag_of_slot [ENTRIES];
    int                    mru_order   [ENTRIES];
    int                    slots_filled = 0;

    t_lookup_res           pending_lookups [$];
    t_dir_row              dir_tab [$];
    logic [BLOCK_W-1:0]    pool [POOL_N];

    int errors       = 0;
    int n_sent       = 0;
    int n_hits       = 0;
    int n_fills      = 0;
    int n_evicts     = 0;
    int tx_idle_pct  = 24;
    int rx_idle_pct  = 76;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    lru_block_cache_directory #(
        .ENTRIES      (ENTRIES),
        .BLOCK_SHIFT  (BLOCK_SHIFT),
        .SECTOR_SHIFT (SECTOR_SHIFT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_block_number  (i_block_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_fill_sector   (o_fill_sector),
        .o_evict_valid   (o_evict_valid),
        .o_evicted_block (o_evicted_block)
    );

    always #5 i_clk = ~i_clk;

    // Look up one block in the model directory, update recency, and return the result.
    function automatic t_lookup_res lru_lookup(input logic [BLOCK_W-1:0] blk);
        t_lookup_res r;
        int          pos;
        int          s;
        bit          found;
        r = '0;
        found = 1'b0;
        pos = 0;
        s = 0;
        // Scan only the slots in use, most recent first.
        for (int i = 0; i < slots_filled; i++) begin
            if (!found && tag_of_slot[mru_order[i]] == blk) begin
                found = 1'b1;
                pos = i;
                s = mru_order[i];
            end
        end
        if (found) begin
            r.hit = 1'b1;
        end else begin
            if (slots_filled < ENTRIES) begin
                // Take the next never-used slot.
                s = slots_filled;
                pos = slots_filled;
                slots_filled++;
            end else begin
                // Directory full: reuse the least recent slot.
                pos = ENTRIES - 1;
                s = mru_order[pos];
                r.evict = 1'b1;
                r.evicted = tag_of_slot[s];
            end
            tag_of_slot[s] = blk;
            if (SHIFT_DIFF >= 0)
                r.sector = SECTOR_W'(blk) << SHIFT_DIFF;
            else
                r.sector = SECTOR_W'(blk >> (-SHIFT_DIFF));
        end
        // Move the touched slot to the front, shifting the more recent ones back.
        for (int p = pos; p > 0; p--)
            mru_order[p] = mru_order[p - 1];
        mru_order[0] = s;
        r.slot = s[SLOT_W-1:0];
        return r;
    endfunction

    function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // Offer one block; hold valid and payload until the transaction is taken.
    task automatic offer(input logic [BLOCK_W-1:0] blk, input logic use_typed,
                         input t_lookup_res typed);
        t_lookup_res pred;
        i_in_valid <= 1'b1;
        i_block_number <= blk;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        // Advance the model on every accepted transaction, typed row or not.
        pred = lru_lookup(blk);
        pending_lookups.push_back(use_typed ? typed : pred);
        n_sent++;
        // Drop valid for a random gap; otherwise leave it high for the next transaction.
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Result side: check each accepted transaction, then pick ready for the next edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                if (pending_lookups.size() == 0) begin
                    errors++;
                    $display("%0t: result with no lookup pending, expected none, got slot %0d",
                             $time, o_slot);
                end else begin
                    t_lookup_res want;
                    want = pending_lookups.pop_front();
                    field_check("hit", 64'(want.hit), 64'(o_hit));
                    field_check("slot", 64'(want.slot), 64'(o_slot));
                    field_check("fill_sector", 64'(want.sector), 64'(o_fill_sector));
                    field_check("evict_valid", 64'(want.evict), 64'(o_evict_valid));
                    field_check("evicted_block", 64'(want.evicted), 64'(o_evicted_block));
                    if (want.hit)
                        n_hits++;
                    else if (want.evict)
                        n_evicts++;
                    else
                        n_fills++;
                end
            end
            // Serve a long hold-off request: keep ready low for a counted stretch.
            if (hold_served != hold_asked) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Stimulus: reset, directed table, then three paced phases, the first opened by output pressure.
    initial begin
        logic [BLOCK_W-1:0] blk;
        logic [BLOCK_W-1:0] last_blk;
        logic [63:0]        wide;
        int                 ws;
        int                 sweep;
        int                 r;

        last_blk = '0;
        ws = 8;
        sweep = 0;

        // Obvious rows carry a typed-in result; the rest lean on the model.
        // Fill slots 0 and 1 with the extremes, then hit both.
        dir_tab.push_back('{'0, 1'b1, '{1'b0, 4'd0, 55'd0, 1'b0, 52'd0}});
        dir_tab.push_back('{BLK_MAX, 1'b1,
                            '{1'b0, 4'd1, 55'h7F_FFFF_FFFF_FFF8, 1'b0, 52'd0}});
        dir_tab.push_back('{'0, 1'b1, '{1'b1, 4'd0, 55'd0, 1'b0, 52'd0}});
        dir_tab.push_back('{BLK_MAX, 1'b1, '{1'b1, 4'd1, 55'd0, 1'b0, 52'd0}});
        // Alternating patterns, top bit alone, one, and a one-bit neighbor of the max.
        dir_tab.push_back('{52'hA_AAAA_AAAA_AAAA, 1'b0, '0});
        dir_tab.push_back('{52'h5_5555_5555_5555, 1'b0, '0});
        dir_tab.push_back('{52'h8_0000_0000_0000, 1'b0, '0});
        dir_tab.push_back('{52'd1, 1'b0, '0});
        dir_tab.push_back('{52'hF_FFFF_FFFF_FFFE, 1'b0, '0});
        // Fill slots 7..15 so the directory is full.
        for (int b = 2; b <= 10; b++)
            dir_tab.push_back('{BLK_MAX & BLOCK_W'(b), 1'b0, '0});
        // Refresh block 0, so block max in slot 1 is now least recent and gets evicted.
        dir_tab.push_back('{'0, 1'b1, '{1'b1, 4'd0, 55'd0, 1'b0, 52'd0}});
        dir_tab.push_back('{52'h123, 1'b1, '{1'b0, 4'd1, 55'h918, 1'b1, BLK_MAX}});
        // Evict again, then hit the last block of the fill run, a middle entry, and block 0x123.
        dir_tab.push_back('{BLK_MAX, 1'b0, '0});
        dir_tab.push_back('{52'd10, 1'b0, '0});
        dir_tab.push_back('{52'd2, 1'b0, '0});
        dir_tab.push_back('{52'h123, 1'b0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            offer(dir_tab[k].blk, dir_tab[k].typed, dir_tab[k].want);

        for (int ph = 0; ph < 3; ph++) begin
            // Pause the sender until every pending lookup has come back.
            i_in_valid <= 1'b0;
            while (pending_lookups.size() != 0) @(posedge i_clk);
            @(posedge i_clk);
            tx_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 76 : 0;
            rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 24 : 0;
            if (ph == 0) begin
                // Hold the output off while offering back to back, so the input stalls.
                hold_asked++;
                tx_idle_pct = 0;
                for (int k = 0; k < 12; k++) begin
                    wide = {$urandom, $urandom};
                    offer(wide[BLOCK_W-1:0], 1'b0, '0);
                end
                tx_idle_pct = 24;
            end
            for (int n = 0; n < 440; n++) begin
                // Refresh the working set now and then; sizes around ENTRIES drive eviction.
                if (n % 60 == 0) begin
                    case ($urandom_range(5))
                        0: ws = 8;
                        1: ws = 15;
                        2: ws = ENTRIES;
                        3: ws = ENTRIES + 1;
                        4: ws = 20;
                        default: ws = POOL_N;
                    endcase
                    sweep = 0;
                    for (int k = 0; k < POOL_N; k++) begin
                        case ($urandom_range(3))
                            0, 1: begin
                                wide = {$urandom, $urandom};
                                pool[k] = wide[BLOCK_W-1:0];
                            end
                            2: pool[k] = BLOCK_W'($urandom_range(255));
                            default: pool[k] = (k == 0) ? '0 : pool[k - 1] + BLOCK_W'(1);
                        endcase
                    end
                end
                r = $urandom_range(99);
                if (r < 50) begin
                    blk = pool[$urandom_range(ws - 1)];
                end else if (r < 62) begin
                    // Cyclic sweep: all hits at the LRU end, or thrashing one past capacity.
                    blk = pool[sweep];
                    sweep = (sweep + 1) % ws;
                end else if (r < 72) begin
                    blk = last_blk;
                end else if (r < 85) begin
                    // Near miss: one bit away from a likely cached tag.
                    blk = pool[$urandom_range(ws - 1)] ^ (52'd1 << $urandom_range(BLOCK_W - 1));
                end else begin
                    wide = {$urandom, $urandom};
                    blk = wide[BLOCK_W-1:0];
                end
                last_blk = blk;
                offer(blk, 1'b0, '0);
            end
        end

        // Drain: wait for every lookup, then wait on for stray results.
        i_in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (2 * (ENTRIES + 5)) @(posedge i_clk);
        $display("Ran %0d lookups: %0d hits, %0d fills into free slots, %0d evictions.",
                 n_sent, n_hits, n_fills, n_evicts);
        $display("Pacing: idle 24/76 then 76/24 then none, plus a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: a correct run finishes far inside this bound.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
